FILE: rtl/idqr_pkg.sv
// Shared types and constants of the integer divide quotient/remainder unit.
`default_nettype none

package idqr_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CELL_WIDTH = 4;
   localparam int NUM_CELLS  = DATA_WIDTH / CELL_WIDTH;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

   localparam logic DIV_UNSIGNED = 1'b0;
   localparam logic DIV_SIGNED   = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } idqr_req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] quotient;
      logic [DATA_WIDTH-1:0] remainder;
      logic                  div_zero;
   } idqr_rsp_type;

   // Control broadcast to every cell of the row.
   typedef struct packed {
      logic load;
      logic shift;
      logic commit;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/int_divide_quotient_remainder_unit.sv
// Top level of the integer divide quotient/remainder unit.
`default_nettype none

// Integer divider returning quotient and remainder of two 32-bit words, signed
// (truncating toward zero, remainder takes the dividend's sign) or unsigned per
// request. A request is taken when start is high and busy is low; the result
// appears on rsp_data for exactly one cycle with rsp_valid high once the run
// and fix-up states are through, and must be captured then: there is no
// back-pressure. The restoring shift-and-subtract loop gives one quotient bit
// per cycle across the row of cells, then come a sign fix-up state and the
// result register. busy drops in the cycle the result is shown, so no new
// request is taken before the last result is shown. A zero divisor raises
// div_zero, quotient 0, remainder all ones (1 if signed, negative dividend).
module int_divide_quotient_remainder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  idqr_pkg::idqr_req_type req_data,
   output logic                   rsp_valid,
   output idqr_pkg::idqr_rsp_type rsp_data
);
   import idqr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIX  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   idqr_rsp_type          rsp_ff, rsp_in;

   // Sign bookkeeping captured with the request.
   logic                  num_neg_ff, num_neg_in;
   logic                  quo_neg_ff, quo_neg_in;
   logic                  div_zero_ff, div_zero_in;

   logic                  accept;
   logic                  num_neg;
   logic                  den_neg;
   logic [DATA_WIDTH-1:0] num_mag;
   logic [DATA_WIDTH-1:0] den_mag;

   cell_ctrl_type         ctrl;
   logic [NUM_CELLS:0]    borrow;
   logic [NUM_CELLS:0]    rem_link;
   logic [NUM_CELLS:0]    quo_link;
   logic [DATA_WIDTH-1:0] rem_vec;
   logic [DATA_WIDTH-1:0] quo_vec;
   logic                  carry;

   logic [DATA_WIDTH-1:0] quo_fix;
   logic [DATA_WIDTH-1:0] rem_base;
   logic [DATA_WIDTH-1:0] rem_fix;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Take operand magnitudes on the way in.
   assign num_neg = (req_data.req_type == DIV_SIGNED) && req_data.dividend[DATA_WIDTH-1];
   assign den_neg = (req_data.req_type == DIV_SIGNED) && req_data.divisor[DATA_WIDTH-1];
   assign num_mag = num_neg ? (~req_data.dividend + 1'b1) : req_data.dividend;
   assign den_mag = den_neg ? (~req_data.divisor + 1'b1) : req_data.divisor;

   // The bit shifted out of the remainder top counts as a carry: subtract anyway.
   assign carry       = rem_link[NUM_CELLS];
   assign ctrl.load   = accept;
   assign ctrl.shift  = (state_ff == ST_RUN);
   assign ctrl.commit = carry || !borrow[NUM_CELLS];

   // Remainder chain is fed from the top of the dividend/quotient chain;
   // the new quotient bit enters the bottom of the dividend/quotient chain.
   assign borrow[0]   = 1'b0;
   assign rem_link[0] = quo_link[NUM_CELLS];
   assign quo_link[0] = ctrl.commit;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      idqr_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .load_num      (num_mag[i*CELL_WIDTH +: CELL_WIDTH]),
         .load_den      (den_mag[i*CELL_WIDTH +: CELL_WIDTH]),
         .rem_shift_in  (rem_link[i]),
         .quo_shift_in  (quo_link[i]),
         .borrow_in     (borrow[i]),
         .rem_shift_out (rem_link[i+1]),
         .quo_shift_out (quo_link[i+1]),
         .borrow_out    (borrow[i+1]),
         .rem           (rem_vec[i*CELL_WIDTH +: CELL_WIDTH]),
         .quo           (quo_vec[i*CELL_WIDTH +: CELL_WIDTH])
      );
   end

   // Sign fix-up and divide-by-zero override.
   assign quo_fix  = div_zero_ff ? '0 : (quo_neg_ff ? (~quo_vec + 1'b1) : quo_vec);
   assign rem_base = div_zero_ff ? '1 : rem_vec;
   assign rem_fix  = num_neg_ff ? (~rem_base + 1'b1) : rem_base;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      num_neg_in   = num_neg_ff;
      quo_neg_in   = quo_neg_ff;
      div_zero_in  = div_zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_RUN;
               count_in    = CNT_WIDTH'(DATA_WIDTH - 1);
               num_neg_in  = num_neg;
               quo_neg_in  = num_neg ^ den_neg;
               div_zero_in = (req_data.divisor == '0);
            end
         end
         ST_RUN: begin
            // Advance one quotient bit per cycle.
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            rsp_in.quotient  = quo_fix;
            rsp_in.remainder = rem_fix;
            rsp_in.div_zero  = div_zero_ff;
            rsp_valid_in     = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      num_neg_ff  <= num_neg_in;
      quo_neg_ff  <= quo_neg_in;
      div_zero_ff <= div_zero_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result strobe only ever follows the fix-up cycle, and the unit is free again.
   a_rsp_after_fix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE) && ($past(state_ff) == ST_FIX))
      else $error("result strobe without fix-up cycle");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (count_ff == CNT_WIDTH'(DATA_WIDTH - 1)))
      else $error("accepted request did not start the iteration");

   a_fix_strobes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |=> rsp_valid)
      else $error("fix-up cycle did not produce a result");

   a_zero_quotient: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_zero) |-> (rsp_data.quotient == '0))
      else $error("divide by zero with nonzero quotient");

endmodule

`default_nettype wire

FILE: rtl/idqr_cell.sv
// One slice of the divider row: remainder, divisor and dividend/quotient bits.
`default_nettype none

module idqr_cell (
   input  logic                                 clock,
   input  idqr_pkg::cell_ctrl_type              ctrl,
   input  logic [idqr_pkg::CELL_WIDTH-1:0]      load_num,
   input  logic [idqr_pkg::CELL_WIDTH-1:0]      load_den,
   input  logic                                 rem_shift_in,
   input  logic                                 quo_shift_in,
   input  logic                                 borrow_in,
   output logic                                 rem_shift_out,
   output logic                                 quo_shift_out,
   output logic                                 borrow_out,
   output logic [idqr_pkg::CELL_WIDTH-1:0]      rem,
   output logic [idqr_pkg::CELL_WIDTH-1:0]      quo
);
   import idqr_pkg::*;

   logic [CELL_WIDTH-1:0] rem_ff, rem_in;
   logic [CELL_WIDTH-1:0] den_ff, den_in;
   logic [CELL_WIDTH-1:0] quo_ff, quo_in;
   logic [CELL_WIDTH-1:0] rem_shifted;
   logic [CELL_WIDTH-1:0] quo_shifted;
   logic [CELL_WIDTH:0]   diff;

   assign rem_shifted = {rem_ff[CELL_WIDTH-2:0], rem_shift_in};
   assign quo_shifted = {quo_ff[CELL_WIDTH-2:0], quo_shift_in};

   // Slice of the trial subtract; borrow ripples to the next cell up.
   assign diff = {1'b0, rem_shifted} - {1'b0, den_ff} - {{CELL_WIDTH{1'b0}}, borrow_in};
   assign borrow_out = diff[CELL_WIDTH];

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      if (ctrl.load) begin
         rem_in = '0;
         den_in = load_den;
         quo_in = load_num;
      end else if (ctrl.shift) begin
         rem_in = ctrl.commit ? diff[CELL_WIDTH-1:0] : rem_shifted;
         quo_in = quo_shifted;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rem_shift_out = rem_ff[CELL_WIDTH-1];
   assign quo_shift_out = quo_ff[CELL_WIDTH-1];
   assign rem           = rem_ff;
   assign quo           = quo_ff;

endmodule

`default_nettype wire
